[rtl/core/klst_pkg.sv]
// package for the keyed latency statistics table
// types, codes and sizes shared by the interfaces, the engine, the top level and the checker
package klst_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int KEY_W      = 32;
    localparam int STAT_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int RSLOT_W    = 10;
    localparam int USED_W     = 11;
    localparam int LIMIT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1001);
    localparam logic [STAT_W-1:0]  THRESH_RESET = STAT_W'(1000);

    typedef enum logic [FUNC_W-1:0] {
        FN_RECORD = 2'd0,
        FN_READ   = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_LIMIT = 2'd0,
        CFG_SLOW_THRESH = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [STAT_W-1:0] total;
        logic [STAT_W-1:0] max;
        logic [STAT_W-1:0] min;
        logic [STAT_W-1:0] ok;
        logic [STAT_W-1:0] fail;
        logic [STAT_W-1:0] slow;
    } t_stats;

    typedef struct packed {
        t_status           status;
        logic [RSLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key_out;
        t_stats            stats;
        logic [USED_W-1:0] entries_used;
    } t_result;

    // one port pair of a simple dual-port memory
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

[rtl/core/klst_ifs.sv]
// channel interfaces of the keyed latency statistics table
// depends on klst_pkg
interface klst_item_if import klst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [KEY_W-1:0]     query_key;
    logic [STAT_W-1:0]    duration;
    logic                 failed;
    logic [RSLOT_W-1:0]   read_slot;

    modport source (output valid, func, query_key, duration, failed, read_slot, input ready);
    modport sink   (input valid, func, query_key, duration, failed, read_slot, output ready);
endinterface

interface klst_result_if import klst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [RSLOT_W-1:0]   slot;
    logic [KEY_W-1:0]     key_out;
    logic [STAT_W-1:0]    total_time;
    logic [STAT_W-1:0]    max_time;
    logic [STAT_W-1:0]    min_time;
    logic [STAT_W-1:0]    ok_count;
    logic [STAT_W-1:0]    fail_count;
    logic [STAT_W-1:0]    slow_count;
    logic [USED_W-1:0]    entries_used;

    modport source (output valid, status, slot, key_out, total_time, max_time, min_time,
                    ok_count, fail_count, slow_count, entries_used, input ready);
    modport sink   (input valid, status, slot, key_out, total_time, max_time, min_time,
                    ok_count, fail_count, slow_count, entries_used, output ready);
endinterface

interface klst_cfg_if import klst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/klst_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module klst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/klst_engine.sv]
// sequencer of the statistics table: key scan, read-modify-write of the entry, reads, clear
// depends on klst_pkg and klst_ifs; drives the key and statistics memories in the top level
module klst_engine import klst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    klst_item_if.sink            i_item,
    input  logic [LIMIT_W-1:0]   i_entry_limit,
    input  logic [STAT_W-1:0]    i_slow_thresh,
    output t_mem_ctl             o_key_ctl,
    output logic [KEY_W-1:0]     o_key_wdata,
    input  logic [KEY_W-1:0]     i_key_rdata,
    output t_mem_ctl             o_stat_ctl,
    output t_stats               o_stat_wdata,
    input  t_stats               i_stat_rdata,
    output logic                 o_res_valid,
    output t_result              o_res,
    input  logic                 i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_UPD,
        S_READ,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [STAT_W-1:0]   r_dur, n_dur;
    logic                r_fail, n_fail;
    logic                r_slow, n_slow;
    t_result             r_res, n_res;

    logic [CNT_W-1:0]    idx_next_cnt;
    logic                scan_last;
    logic                table_full;
    t_stats              upd_stats;
    t_stats              ins_stats;
    logic [CNT_W-1:0]    used_inc;

    assign idx_next_cnt = CNT_W'(r_idx) + CNT_W'(1);
    assign scan_last    = (idx_next_cnt == r_used);
    assign table_full   = (USED_W'(r_used) >= i_entry_limit) || (r_used >= CNT_W'(TABLE_DEPTH));
    assign used_inc     = r_used + CNT_W'(1);

    // entry after a hit
    always_comb begin
        upd_stats = i_stat_rdata;
        if (r_fail) begin
            upd_stats.fail = i_stat_rdata.fail + STAT_W'(1);
        end else begin
            if (i_stat_rdata.max < r_dur) upd_stats.max = r_dur;
            if (i_stat_rdata.min > r_dur) upd_stats.min = r_dur;
            upd_stats.total = i_stat_rdata.total + r_dur;
            upd_stats.ok    = i_stat_rdata.ok + STAT_W'(1);
        end
        if (r_slow) begin
            upd_stats.slow = i_stat_rdata.slow + STAT_W'(1);
        end
    end

    // entry for a new key; a failure-first entry keeps its timing fields at zero
    always_comb begin
        ins_stats      = '0;
        ins_stats.slow = STAT_W'(r_slow);
        if (r_fail) begin
            ins_stats.fail = STAT_W'(1);
        end else begin
            ins_stats.total = r_dur;
            ins_stats.max   = r_dur;
            ins_stats.min   = r_dur;
            ins_stats.ok    = STAT_W'(1);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_idx        = r_idx;
        n_key        = r_key;
        n_dur        = r_dur;
        n_fail       = r_fail;
        n_slow       = r_slow;
        n_res        = r_res;
        o_key_ctl    = '0;
        o_stat_ctl   = '0;
        o_key_wdata  = r_key;
        o_stat_wdata = ins_stats;
        i_item.ready = 1'b0;
        o_res_valid  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    unique case (t_func'(i_item.func))
                        FN_RECORD: begin
                            n_key  = i_item.query_key;
                            n_dur  = i_item.duration;
                            n_fail = i_item.failed;
                            n_slow = i_item.duration > i_slow_thresh;
                            n_idx  = '0;
                            if (r_used == '0) begin
                                n_state = S_MISS;
                            end else begin
                                o_key_ctl.rd_en   = 1'b1;
                                o_key_ctl.rd_addr = '0;
                                n_state           = S_SCAN;
                            end
                        end
                        FN_READ: begin
                            if (CNT_W'(i_item.read_slot) < r_used) begin
                                o_key_ctl.rd_en    = 1'b1;
                                o_key_ctl.rd_addr  = SLOT_W'(i_item.read_slot);
                                o_stat_ctl.rd_en   = 1'b1;
                                o_stat_ctl.rd_addr = SLOT_W'(i_item.read_slot);
                                n_idx              = SLOT_W'(i_item.read_slot);
                                n_state            = S_READ;
                            end else begin
                                n_res              = '0;
                                n_res.status       = ST_EMPTY;
                                n_res.slot         = i_item.read_slot;
                                n_res.entries_used = USED_W'(r_used);
                                n_state            = S_EMIT;
                            end
                        end
                        FN_CLEAR: begin
                            n_used        = '0;
                            n_res         = '0;
                            n_res.status  = ST_CLEARED;
                            n_state       = S_EMIT;
                        end
                        default: begin
                            // unused code: no transaction on the result side
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_key_rdata == r_key) begin
                    o_stat_ctl.rd_en   = 1'b1;
                    o_stat_ctl.rd_addr = r_idx;
                    n_state            = S_UPD;
                end else if (scan_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx             = SLOT_W'(idx_next_cnt);
                    o_key_ctl.rd_en   = 1'b1;
                    o_key_ctl.rd_addr = SLOT_W'(idx_next_cnt);
                end
            end
            S_MISS: begin
                n_res         = '0;
                n_res.key_out = r_key;
                if (table_full) begin
                    n_res.status       = ST_DROPPED;
                    n_res.entries_used = USED_W'(r_used);
                end else begin
                    o_key_ctl.wr_en    = 1'b1;
                    o_key_ctl.wr_addr  = SLOT_W'(r_used);
                    o_stat_ctl.wr_en   = 1'b1;
                    o_stat_ctl.wr_addr = SLOT_W'(r_used);
                    n_used             = used_inc;
                    n_res.status       = ST_INSERTED;
                    n_res.slot         = RSLOT_W'(r_used);
                    n_res.stats        = ins_stats;
                    n_res.entries_used = USED_W'(used_inc);
                end
                n_state = S_EMIT;
            end
            S_UPD: begin
                o_stat_ctl.wr_en   = 1'b1;
                o_stat_ctl.wr_addr = r_idx;
                o_stat_wdata       = upd_stats;
                n_res.status       = ST_UPDATED;
                n_res.slot         = RSLOT_W'(r_idx);
                n_res.key_out      = r_key;
                n_res.stats        = upd_stats;
                n_res.entries_used = USED_W'(r_used);
                n_state            = S_EMIT;
            end
            S_READ: begin
                n_res.status       = ST_READ_OK;
                n_res.slot         = RSLOT_W'(r_idx);
                n_res.key_out      = i_key_rdata;
                n_res.stats        = i_stat_rdata;
                n_res.entries_used = USED_W'(r_used);
                n_state            = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_dur  <= n_dur;
        r_fail <= n_fail;
        r_slow <= n_slow;
        r_res  <= n_res;
    end

endmodule

[rtl/core/keyed_latency_stats_table_unit.sv]
// channel      | role    | moves per transaction
// i_item       | sink    | func, query_key, duration, failed, read_slot
// o_result     | source  | status, slot, key_out, six counters, entries_used
// i_cfg        | sink    | index 0 entry_limit, index 1 slow_threshold, data
// one item at a time; a record scans the stored keys from slot 0, one key per cycle,
// until it hits its key or passes the last used entry; a miss then inserts or drops
// a read of an occupied slot reads both memories; an empty read or a clear does not
// reset clears the entry count and the control state; the memories need no clearing pass
// a stalled result sits in the output register; the next item is taken meanwhile and
// its result waits in the engine until that register frees
// depends on klst_pkg, klst_ifs, klst_ram and klst_engine
module keyed_latency_stats_table_unit import klst_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    klst_item_if.sink      i_item,
    klst_result_if.source  o_result,
    klst_cfg_if.sink       i_cfg
);

    logic [LIMIT_W-1:0] r_entry_limit;
    logic [STAT_W-1:0]  r_slow_thresh;
    logic               r_out_valid;
    t_result            r_out;

    t_mem_ctl           key_ctl;
    t_mem_ctl           stat_ctl;
    logic [KEY_W-1:0]   key_wdata;
    logic [KEY_W-1:0]   key_rdata;
    t_stats             stat_wdata;
    t_stats             stat_rdata;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= LIMIT_RESET;
            r_slow_thresh <= THRESH_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_ENTRY_LIMIT: r_entry_limit <= i_cfg.data[LIMIT_W-1:0];
                CFG_SLOW_THRESH: r_slow_thresh <= i_cfg.data[STAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    klst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_ctl.wr_en),
        .i_wr_addr (key_ctl.wr_addr),
        .i_wr_data (key_wdata),
        .i_rd_en   (key_ctl.rd_en),
        .i_rd_addr (key_ctl.rd_addr),
        .o_rd_data (key_rdata)
    );

    klst_ram #(
        .WIDTH ($bits(t_stats)),
        .DEPTH (TABLE_DEPTH)
    ) u_stat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stat_ctl.wr_en),
        .i_wr_addr (stat_ctl.wr_addr),
        .i_wr_data (stat_wdata),
        .i_rd_en   (stat_ctl.rd_en),
        .i_rd_addr (stat_ctl.rd_addr),
        .o_rd_data (stat_rdata)
    );

    klst_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_entry_limit (r_entry_limit),
        .i_slow_thresh (r_slow_thresh),
        .o_key_ctl     (key_ctl),
        .o_key_wdata   (key_wdata),
        .i_key_rdata   (key_rdata),
        .o_stat_ctl    (stat_ctl),
        .o_stat_wdata  (stat_wdata),
        .i_stat_rdata  (stat_rdata),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    // output register frees when empty or taken this cycle
    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.slot         = r_out.slot;
    assign o_result.key_out      = r_out.key_out;
    assign o_result.total_time   = r_out.stats.total;
    assign o_result.max_time     = r_out.stats.max;
    assign o_result.min_time     = r_out.stats.min;
    assign o_result.ok_count     = r_out.stats.ok;
    assign o_result.fail_count   = r_out.stats.fail;
    assign o_result.slow_count   = r_out.stats.slow;
    assign o_result.entries_used = r_out.entries_used;

endmodule

[rtl/core/klst_checker.sv]
// port-level checks on the result channel of the statistics table, with its bind
// depends on klst_pkg and keyed_latency_stats_table_unit
module klst_checker import klst_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [RSLOT_W-1:0]  i_slot,
    input logic [KEY_W-1:0]    i_key_out,
    input logic [STAT_W-1:0]   i_ok_count,
    input logic [STAT_W-1:0]   i_fail_count,
    input logic [USED_W-1:0]   i_entries_used
);

    // a stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_key_out) && $stable(i_slot))
        else $error("result changed while stalled");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_CLEARED |->
            i_entries_used == '0 && i_key_out == '0 && i_slot == '0)
        else $error("clear result not empty");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DROPPED |->
            i_slot == '0 && i_ok_count == '0 && i_fail_count == '0)
        else $error("dropped record carries entry data");

    // a new entry has seen exactly one event
    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_INSERTED |->
            ((i_ok_count == STAT_W'(1) && i_fail_count == '0) ||
             (i_ok_count == '0 && i_fail_count == STAT_W'(1))) &&
            i_entries_used == USED_W'(i_slot) + USED_W'(1))
        else $error("inserted entry malformed");

endmodule

bind keyed_latency_stats_table_unit klst_checker u_klst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_status       (o_result.status),
    .i_slot         (o_result.slot),
    .i_key_out      (o_result.key_out),
    .i_ok_count     (o_result.ok_count),
    .i_fail_count   (o_result.fail_count),
    .i_entries_used (o_result.entries_used)
);
